// ===== src/slc_pkg.sv =====
// Shared types and constants for the slot cache LRU lookup unit.
package slc_pkg;

    localparam int CACHE_ENTRIES_DEF = 64;
    localparam int TAG_W             = 16;
    localparam int STAMP_W           = 32;
    localparam int IDX_OUT_W         = 6;
    localparam int ENTRY_W           = 2 * TAG_W + STAMP_W;

    localparam logic CMD_QUERY      = 1'b0;
    localparam logic CMD_INVALIDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } slc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the accepted item
        logic rd;         // read the entry at the scan address
        logic clr_valid;  // drop every valid bit
        logic finish;     // load the result and update the used entry
    } slc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } slc_sts_t;

endpackage

// ===== src/slc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== src/slc_ctrl.sv =====
// Sequencer for the slot cache: accept, scan all entries for a query (an invalidate skips the scan), finish.
module slc_ctrl
    import slc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    input  logic                             in_cmd,
    output logic                             in_ready,
    input  slc_sts_t                         sts,
    output slc_cmd_t                         cmd,
    output logic [$clog2(CACHE_ENTRIES)-1:0] addr
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    slc_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        addr       = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    if (in_cmd == CMD_INVALIDATE) begin
                        cmd.clr_valid = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd = 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            // last read data is compared in this cycle
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/slc_datapath.sv =====
// Entry store, tag compare, oldest-stamp tracking and result register.
module slc_datapath
    import slc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  slc_cmd_t                         cmd,
    input  logic [$clog2(CACHE_ENTRIES)-1:0] addr,
    output slc_sts_t                         sts,
    input  logic                             in_cmd,
    input  logic signed [TAG_W-1:0]          in_slot_x,
    input  logic signed [TAG_W-1:0]          in_slot_z,
    input  logic [STAMP_W-1:0]               in_frame,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_hit,
    output logic [IDX_OUT_W-1:0]             out_entry_index,
    output logic                             out_victim_was_valid
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    // captured item
    logic                      inv_reg;
    logic signed [TAG_W-1:0]   qx_reg;
    logic signed [TAG_W-1:0]   qz_reg;
    logic [STAMP_W-1:0]        fr_reg;

    // per-entry flags: valid clears on invalidate, written clears only on reset
    logic [CACHE_ENTRIES-1:0]  valid_reg;
    logic [CACHE_ENTRIES-1:0]  written_reg;

    logic                      p_vld_reg;
    logic [IDX_W-1:0]          p_idx_reg;

    logic                      hit_found_reg;
    logic [IDX_W-1:0]          hit_idx_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic [STAMP_W-1:0]        best_stamp_reg;

    logic                      out_valid_reg;
    logic                      out_hit_reg;
    logic [IDX_OUT_W-1:0]      out_idx_reg;
    logic                      out_vwv_reg;

    logic [ENTRY_W-1:0]        rdata;
    logic signed [TAG_W-1:0]   rd_x;
    logic signed [TAG_W-1:0]   rd_z;
    logic [STAMP_W-1:0]        rd_stamp;
    logic                      match;
    logic [IDX_W-1:0]          use_idx;
    logic                      ram_we;

    assign rd_x     = rdata[ENTRY_W-1 -: TAG_W];
    assign rd_z     = rdata[STAMP_W +: TAG_W];
    // an entry never written reads as stamp zero
    assign rd_stamp = written_reg[p_idx_reg] ? rdata[STAMP_W-1:0] : '0;
    assign match    = valid_reg[p_idx_reg] && (rd_x == qx_reg) && (rd_z == qz_reg);
    assign use_idx  = hit_found_reg ? hit_idx_reg : best_idx_reg;
    assign ram_we   = cmd.finish && !inv_reg;

    // on a hit the stored tags equal the query, so one write covers both cases
    slc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (use_idx),
        .wdata ({qx_reg, qz_reg, fr_reg}),
        .re    (cmd.rd),
        .raddr (addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            inv_reg <= in_cmd;
            qx_reg  <= in_slot_x;
            qz_reg  <= in_slot_z;
            fr_reg  <= in_frame;
        end
        p_idx_reg <= addr;
        if (p_vld_reg) begin
            if (match && !hit_found_reg) begin
                hit_idx_reg <= p_idx_reg;
            end
            // strict compare keeps the lowest index on ties
            if (p_idx_reg == '0 || rd_stamp < best_stamp_reg) begin
                best_idx_reg   <= p_idx_reg;
                best_stamp_reg <= rd_stamp;
            end
        end
        if (cmd.finish) begin
            out_hit_reg <= !inv_reg && hit_found_reg;
            out_idx_reg <= inv_reg ? '0 : IDX_OUT_W'(use_idx);
            out_vwv_reg <= !inv_reg && !hit_found_reg && valid_reg[best_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            written_reg   <= '0;
            p_vld_reg     <= 1'b0;
            hit_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p_vld_reg <= cmd.rd;
            if (cmd.capture) begin
                hit_found_reg <= 1'b0;
            end else if (p_vld_reg && match) begin
                hit_found_reg <= 1'b1;
            end
            if (cmd.clr_valid) begin
                valid_reg <= '0;
            end else if (ram_we) begin
                valid_reg[use_idx]   <= 1'b1;
                written_reg[use_idx] <= 1'b1;
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free        = !out_valid_reg || out_ready;
    assign out_valid           = out_valid_reg;
    assign out_hit             = out_hit_reg;
    assign out_entry_index     = out_idx_reg;
    assign out_victim_was_valid = out_vwv_reg;

endmodule

// ===== src/slot_cache_lru_lookup_unit.sv =====
// Top level of the slot cache LRU lookup unit.
// Fully associative cache of CACHE_ENTRIES grid-slot tags with frame-stamp LRU
// replacement. A query (s_tuser = 0) scans every entry, one per cycle, through
// the single read port of the entry RAM, and the block takes no new item until
// the scan, the drain state and the final update are through; an invalidate
// (s_tuser = 1) clears all valid bits at once. One item is worked on at a time;
// the result sits in an output register and the final update waits only while
// that register is still full. Each accepted item yields exactly one result
// transfer.
module slot_cache_lru_lookup_unit
    import slc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // slot_x[15:0], slot_z[31:16], frame[63:32]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // hit[0], entry_index[6:1], victim_was_valid[7]
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    slc_cmd_t          cmd;
    slc_sts_t          sts;
    logic [IDX_W-1:0]  addr;
    logic              out_hit;
    logic [IDX_OUT_W-1:0] out_idx;
    logic              out_vwv;

    slc_ctrl #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser[0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .addr     (addr)
    );

    slc_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .addr                 (addr),
        .sts                  (sts),
        .in_cmd               (s_tuser[0]),
        .in_slot_x            (s_tdata[15:0]),
        .in_slot_z            (s_tdata[31:16]),
        .in_frame             (s_tdata[63:32]),
        .out_valid            (m_tvalid),
        .out_ready            (m_tready),
        .out_hit              (out_hit),
        .out_entry_index      (out_idx),
        .out_victim_was_valid (out_vwv)
    );

    assign m_tdata = {out_vwv, out_idx, out_hit};

endmodule

// ===== src/slc_checker.sv =====
// Port-level checks for the slot cache LRU lookup unit, bound to the top level.
module slc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // result held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // one item in flight: no transfer right after an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item still busy");

    // a hit never reports a replaced entry
    a_hit_no_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[7])
        else $error("hit result with victim flag set");

    // an invalidate accepted with no result pending ends with an all-zero result
    a_inv_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> ##1
            m_tvalid && m_tdata == 8'd0)
        else $error("invalidate result wrong or late");

endmodule

bind slot_cache_lru_lookup_unit slc_checker u_slc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_slot_cache_lru_lookup_unit.sv =====
// Testbench for the slot cache LRU lookup unit: directed and random queries checked against a local cache model.
module tb_slot_cache_lru_lookup_unit;
    import slc_pkg::*;

    localparam int N_ENTRIES  = CACHE_ENTRIES_DEF;
    localparam int N_RANDOM   = 700;
    localparam int POOL_SIZE  = 96;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYC  = 2 * N_ENTRIES + 10;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        logic               cmd;
        logic signed [15:0] slot_x;
        logic signed [15:0] slot_z;
        logic [31:0]        frame;
    } slot_req_t;

    typedef struct {
        logic       hit;
        logic [5:0] entry_index;
        logic       victim_was_valid;
    } slot_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // cache model state
    logic [15:0] tag_x_m [N_ENTRIES];
    logic [15:0] tag_z_m [N_ENTRIES];
    logic        valid_m [N_ENTRIES];
    logic [31:0] stamp_m [N_ENTRIES];

    slot_req_t    slot_requests[$];
    slot_result_t expected_lookups[$];
    slot_req_t    cur_req;

    int errors      = 0;
    int sent_cnt    = 0;
    int result_cnt  = 0;
    int total_items = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int idle_cyc    = 0;
    int hit_cnt     = 0;
    int miss_cnt    = 0;
    int evict_cnt   = 0;
    int inval_cnt   = 0;

    slot_cache_lru_lookup_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Apply one command to the model and return the result it must produce.
    function automatic slot_result_t lookup_and_stamp(slot_req_t req);
        slot_result_t res;
        int           oldest;
        res    = '{hit: 1'b0, entry_index: '0, victim_was_valid: 1'b0};
        oldest = 0;
        if (req.cmd == CMD_INVALIDATE) begin
            for (int i = 0; i < N_ENTRIES; i++) valid_m[i] = 1'b0;
            return res;
        end
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (valid_m[i] && tag_x_m[i] == req.slot_x && tag_z_m[i] == req.slot_z) begin
                stamp_m[i]      = req.frame;
                res.hit         = 1'b1;
                res.entry_index = i[5:0];
                return res;
            end
            if (stamp_m[i] < stamp_m[oldest]) oldest = i;
        end
        res.entry_index      = oldest[5:0];
        res.victim_was_valid = valid_m[oldest];
        tag_x_m[oldest] = req.slot_x;
        tag_z_m[oldest] = req.slot_z;
        valid_m[oldest] = 1'b1;
        stamp_m[oldest] = req.frame;
        return res;
    endfunction

    task automatic add_req(logic cmd, logic [15:0] x, logic [15:0] z, logic [31:0] fr);
        slot_req_t req;
        req.cmd    = cmd;
        req.slot_x = x;
        req.slot_z = z;
        req.frame  = fr;
        slot_requests.insert(slot_requests.size(), req);
    endtask

    // Sender: present one item at a time, predict on each transfer.
    always @(posedge aclk) begin
        logic next_valid;
        next_valid = s_tvalid;
        if (!aresetn) begin
            next_valid = 1'b0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_lookups.insert(expected_lookups.size(), lookup_and_stamp(cur_req));
                if (cur_req.cmd == CMD_INVALIDATE) inval_cnt++;
                sent_cnt++;
                next_valid = 1'b0;
                // every fourth block of 64 items runs back to back
                gap_left = ((sent_cnt / 64) % 4 == 3) ? 0 : $urandom_range(0, 18);
            end else if (!s_tvalid && gap_left > 0) begin
                gap_left--;
            end
            if (!next_valid && gap_left == 0 && slot_requests.size() != 0) begin
                cur_req = slot_requests.pop_front();
                s_tdata <= {cur_req.frame, cur_req.slot_z, cur_req.slot_x};
                s_tuser <= cur_req.cmd;
                next_valid = 1'b1;
            end
        end
        s_tvalid <= next_valid;
    end

    // Receiver: check each transfer against the oldest prediction.
    always @(posedge aclk) begin
        slot_result_t got;
        slot_result_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.hit              = m_tdata[0];
                got.entry_index      = m_tdata[6:1];
                got.victim_was_valid = m_tdata[7];
                if (expected_lookups.size() == 0) begin
                    $error("unexpected result transfer: m_tdata=%h", m_tdata);
                    errors++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        errors++;
                    end
                    if (got.entry_index !== want.entry_index) begin
                        $error("entry_index: expected %0d, got %0d",
                               want.entry_index, got.entry_index);
                        errors++;
                    end
                    if (got.victim_was_valid !== want.victim_was_valid) begin
                        $error("victim_was_valid: expected %0d, got %0d",
                               want.victim_was_valid, got.victim_was_valid);
                        errors++;
                    end
                    if (want.hit) hit_cnt++;
                    else miss_cnt++;
                    if (want.victim_was_valid) evict_cnt++;
                end
                result_cnt++;
                // one long hold so the block backs up onto its input
                if (result_cnt == 150) stall_left = LONG_HOLD;
                else if ((result_cnt / 64) % 4 == 1) stall_left = 0;
                else stall_left = $urandom_range(0, 18);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc = 0;
            else idle_cyc++;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cyc);
                $display("tb_slot_cache_lru_lookup_unit NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] pool_x [POOL_SIZE];
        logic [15:0] pool_z [POOL_SIZE];
        logic [31:0] frame_now;
        logic [31:0] fr;
        int          r;
        int          k;

        for (int i = 0; i < N_ENTRIES; i++) begin
            tag_x_m[i] = '0;
            tag_z_m[i] = '0;
            valid_m[i] = 1'b0;
            stamp_m[i] = '0;
        end

        // Directed: reset tags match (0,0) but are invalid, then hits,
        // field extremes, invalidate with junk fields, and stamp ties.
        add_req(CMD_QUERY,      16'sd0,     16'sd0,     32'd0);
        add_req(CMD_QUERY,      16'sd0,     16'sd0,     32'd1);
        add_req(CMD_QUERY,      16'h8000,   16'h7fff,   32'd2);
        add_req(CMD_QUERY,      16'h7fff,   16'h8000,   32'hffff_ffff);
        add_req(CMD_QUERY,      16'hffff,   16'hffff,   32'h8000_0000);
        add_req(CMD_QUERY,      16'h8000,   16'h7fff,   32'd3);
        add_req(CMD_QUERY,      16'h7fff,   16'h8000,   32'd0);
        add_req(CMD_INVALIDATE, 16'hffff,   16'hffff,   32'hffff_ffff);
        add_req(CMD_QUERY,      16'sd0,     16'sd0,     32'd4);
        add_req(CMD_QUERY,      16'h8000,   16'h7fff,   32'd5);
        add_req(CMD_QUERY,      16'sd0,     16'sd0,     32'd6);
        add_req(CMD_INVALIDATE, 16'h0000,   16'h0000,   32'd0);
        add_req(CMD_QUERY,      16'h7fff,   16'h7fff,   32'd0);
        add_req(CMD_QUERY,      16'h8000,   16'h8000,   32'd0);
        add_req(CMD_QUERY,      16'h7fff,   16'h7fff,   32'd7);

        // Random: mostly a working set near the origin with slowly
        // advancing frames, plus far slots, odd frames and invalidates.
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < 64) begin
                pool_x[i] = 16'($signed($urandom_range(0, 15)) - 8);
                pool_z[i] = 16'($signed($urandom_range(0, 15)) - 8);
            end else begin
                pool_x[i] = 16'($urandom);
                pool_z[i] = 16'($urandom);
            end
        end
        frame_now = 32'd16;
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                add_req(CMD_INVALIDATE, 16'($urandom), 16'($urandom), $urandom);
            end else begin
                frame_now = frame_now + $urandom_range(0, 3);
                fr = (r < 8) ? 32'($urandom) : frame_now;
                if (r < 14) begin
                    add_req(CMD_QUERY, 16'($urandom), 16'($urandom), fr);
                end else begin
                    k = $urandom_range(0, POOL_SIZE - 1);
                    add_req(CMD_QUERY, pool_x[k], pool_z[k], fr);
                end
            end
        end
        total_items = slot_requests.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (sent_cnt < total_items || expected_lookups.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (expected_lookups.size() != 0) begin
            $error("%0d expected results never arrived", expected_lookups.size());
            errors++;
        end

        $display("%0d items sent, %0d results: %0d hits, %0d misses, %0d valid evictions",
                 sent_cnt, result_cnt, hit_cnt, miss_cnt, evict_cnt);
        $display("%0d invalidates, %0d check errors", inval_cnt, errors);
        if (errors == 0) begin
            $display("tb_slot_cache_lru_lookup_unit OK");
        end else begin
            $display("tb_slot_cache_lru_lookup_unit NOT OK");
        end
        $finish;
    end

endmodule
